### hdl/denied_access_counter_table_defines.svh
// Assertion macros for the denied-access counter table.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef DENIED_ACCESS_COUNTER_TABLE_DEFINES_SVH
`define DENIED_ACCESS_COUNTER_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define DACT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define DACT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/dact_pkg.sv
// Shared types and constants for the denied-access counter table.
// No dependencies; imported by dact_cell and the top level.
`timescale 1ns / 1ps
`default_nettype none

package dact_pkg;

  localparam int unsigned ID_W      = 32;
  localparam int unsigned THR_W     = 16;
  localparam int unsigned OUT_CNT_W = 16;
  localparam logic [THR_W-1:0] THR_RESET = 16'd5;

  // Controller states
  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } dact_state_e;

  // Control broadcast from the controller to every cell
  typedef struct packed {
    logic record;    // denied log record this cycle
    logic any_hit;   // some cell holds the record's user
    logic clr_seen;  // start of a report run
    logic shift;     // rotate the chain by one place towards the head
  } dact_ctrl_t;

endpackage

`default_nettype wire

### hdl/dact_cell.sv
// One table cell: a user ID, its saturating denial count and flags.
// Depends on dact_pkg. Cells form a ring that rotates during a report.
`timescale 1ns / 1ps
`default_nettype none

module dact_cell #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  dact_pkg::dact_ctrl_t           ctrl_i,
  input  logic [dact_pkg::ID_W-1:0]      rec_id_i,
  input  logic [dact_pkg::THR_W-1:0]     thr_i,
  input  logic                           prev_valid_i,
  input  logic                           nxt_valid_i,
  input  logic [dact_pkg::ID_W-1:0]      nxt_id_i,
  input  logic [COUNT_BITS-1:0]          nxt_cnt_i,
  input  logic                           nxt_seen_i,
  output logic                           valid_o,
  output logic [dact_pkg::ID_W-1:0]      id_o,
  output logic [COUNT_BITS-1:0]          cnt_o,
  output logic                           seen_o,
  output logic                           match_o,
  output logic                           pend_o
);
  import dact_pkg::*;

  localparam int unsigned CMP_W = (COUNT_BITS > THR_W) ? COUNT_BITS : THR_W;

  logic                  valid_q, valid_d;
  logic                  seen_q, seen_d;
  logic [ID_W-1:0]       id_q, id_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  logic [CMP_W-1:0]      cnt_ext, thr_ext;
  logic                  alloc;

  // Local compare against the record and the threshold
  assign cnt_ext = CMP_W'(cnt_q);
  assign thr_ext = CMP_W'(thr_i);
  assign match_o = valid_q && (id_q == rec_id_i);
  assign pend_o  = valid_q && !seen_q && (cnt_ext > thr_ext);

  // First free cell takes a new user
  assign alloc = ctrl_i.record && !ctrl_i.any_hit && prev_valid_i && !valid_q;

  // Next-state of the cell
  always_comb begin
    valid_d = valid_q;
    seen_d  = seen_q;
    id_d    = id_q;
    cnt_d   = cnt_q;
    if (ctrl_i.shift) begin
      valid_d = nxt_valid_i;
      seen_d  = nxt_seen_i;
      id_d    = nxt_id_i;
      cnt_d   = nxt_cnt_i;
    end else if (ctrl_i.clr_seen) begin
      seen_d = 1'b0;
    end else if (ctrl_i.record) begin
      if (match_o && (cnt_q != '1)) begin
        cnt_d = cnt_q + 1'b1;
      end
      if (alloc) begin
        valid_d = 1'b1;
        id_d    = rec_id_i;
        cnt_d   = COUNT_BITS'(1);
      end
    end
  end

  // Flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      seen_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      seen_q  <= seen_d;
    end
  end

  // Entry word, qualified by valid_q
  always_ff @(posedge clk_i) begin
    id_q  <= id_d;
    cnt_q <= cnt_d;
  end

  assign valid_o = valid_q;
  assign id_o    = id_q;
  assign cnt_o   = cnt_q;
  assign seen_o  = seen_q;

endmodule

`default_nettype wire

### hdl/denied_access_counter_table.sv
// Channel  | Handshake               | Word
// ---------+-------------------------+------------------------------------------
// in       | in_valid_i / in_ready_o | action_i, user_id_i, denied_i
// out      | out_valid_o/out_ready_i | reported_user_o, deny_count_o, found_o,
//          |                         | table_overflowed_o, last_o
// cfg      | cfg_we_i                | cfg_wdata_i (deny threshold)
//
// For a log record, all cells compare the user ID in parallel.
// A report rotates the ring of MAX_USERS cells once, one place per cycle unless
// a qualifying head waits on a full output; with no qualifying user it only
// emits an empty marker word. Input is not taken while a report runs.
// Reset empties the table at once (per-cell valid bits) and sets threshold 5.
// Registered output; a qualifying head holds the ring while the output is full.
//
// Depends on dact_pkg, dact_cell and denied_access_counter_table_defines.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "denied_access_counter_table_defines.svh"

module denied_access_counter_table #(
  parameter int unsigned MAX_USERS  = 32,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input words
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            action_i,
  input  logic [dact_pkg::ID_W-1:0]       user_id_i,
  input  logic                            denied_i,
  // result words
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [dact_pkg::ID_W-1:0]       reported_user_o,
  output logic [dact_pkg::OUT_CNT_W-1:0]  deny_count_o,
  output logic                            found_o,
  output logic                            table_overflowed_o,
  output logic                            last_o,
  // threshold register
  input  logic                            cfg_we_i,
  input  logic [dact_pkg::THR_W-1:0]      cfg_wdata_i
);
  import dact_pkg::*;

  localparam int unsigned CMP_W  = (COUNT_BITS > THR_W) ? COUNT_BITS : THR_W;
  localparam int unsigned STEP_W = (MAX_USERS > 1) ? $clog2(MAX_USERS) : 1;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(MAX_USERS - 1);

  dact_state_e state_q, state_d;
  dact_ctrl_t  ctrl;

  logic [THR_W-1:0]      thr_q;
  logic                  ovf_q;
  logic [STEP_W-1:0]     step_q;

  logic [MAX_USERS-1:0]  valid_vec, seen_vec, match_vec, pend_vec;
  logic [ID_W-1:0]       id_arr  [MAX_USERS];
  logic [COUNT_BITS-1:0] cnt_arr [MAX_USERS];

  logic accept, rec_acc, report_acc, any_hit;
  logic head_pend, any_pend, more_pend, slot_free;
  logic shift, load, marker, step_inc, done;
  logic [CMP_W-1:0] head_cnt_ext;

  logic                  out_valid_q;
  logic [ID_W-1:0]       out_user_q;
  logic [OUT_CNT_W-1:0]  out_cnt_q;
  logic                  out_found_q, out_ovf_q, out_last_q;

  // Input handshake and decode
  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign rec_acc    = accept && !action_i && denied_i;
  assign report_acc = accept && action_i;

  // Reductions over the ring
  assign any_hit   = |match_vec;
  assign head_pend = pend_vec[0];
  assign any_pend  = |pend_vec;
  assign more_pend = |(pend_vec >> 1);
  assign slot_free = !out_valid_q || out_ready_i;

  assign ctrl.record   = rec_acc;
  assign ctrl.any_hit  = any_hit;
  assign ctrl.clr_seen = report_acc;
  assign ctrl.shift    = shift;

  // Ring of cells; each takes its upper neighbour, the tail takes the head
  for (genvar i = 0; i < MAX_USERS; i++) begin : g_cell
    logic            prev_v, nv, ns;
    logic [ID_W-1:0] nid;
    logic [COUNT_BITS-1:0] ncnt;

    if (i == 0) begin : g_head
      assign prev_v = 1'b1;
    end else begin : g_body
      assign prev_v = valid_vec[i-1];
    end

    if (i == MAX_USERS - 1) begin : g_tail
      assign nv   = valid_vec[0];
      assign nid  = id_arr[0];
      assign ncnt = cnt_arr[0];
      assign ns   = 1'b1;
    end else begin : g_link
      assign nv   = valid_vec[i+1];
      assign nid  = id_arr[i+1];
      assign ncnt = cnt_arr[i+1];
      assign ns   = seen_vec[i+1];
    end

    dact_cell #(
      .COUNT_BITS (COUNT_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .rec_id_i     (user_id_i),
      .thr_i        (thr_q),
      .prev_valid_i (prev_v),
      .nxt_valid_i  (nv),
      .nxt_id_i     (nid),
      .nxt_cnt_i    (ncnt),
      .nxt_seen_i   (ns),
      .valid_o      (valid_vec[i]),
      .id_o         (id_arr[i]),
      .cnt_o        (cnt_arr[i]),
      .seen_o       (seen_vec[i]),
      .match_o      (match_vec[i]),
      .pend_o       (pend_vec[i])
    );
  end

  // Controller outputs
  always_comb begin
    shift    = 1'b0;
    load     = 1'b0;
    marker   = 1'b0;
    step_inc = 1'b0;
    done     = 1'b0;
    case (state_q)
      ST_SCAN: begin
        if ((step_q == '0) && !any_pend) begin
          // nobody qualifies: one empty marker
          if (slot_free) begin
            load   = 1'b1;
            marker = 1'b1;
            done   = 1'b1;
          end
        end else if (!head_pend || slot_free) begin
          shift = 1'b1;
          load  = head_pend;
          if (step_q == LAST_STEP) begin
            done = 1'b1;
          end else begin
            step_inc = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // Controller next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (report_acc) state_d = ST_SCAN;
      ST_SCAN: if (done) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      thr_q       <= THR_RESET;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (report_acc) begin
        step_q <= '0;
      end else if (step_inc) begin
        step_q <= step_q + 1'b1;
      end
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      if (rec_acc && !any_hit && valid_vec[MAX_USERS-1]) begin
        ovf_q <= 1'b1;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result word
  assign head_cnt_ext = CMP_W'(cnt_arr[0]);

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_user_q  <= marker ? '0 : id_arr[0];
      out_cnt_q   <= marker ? '0 : head_cnt_ext[OUT_CNT_W-1:0];
      out_found_q <= !marker;
      out_ovf_q   <= ovf_q;
      out_last_q  <= marker || !more_pend;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign reported_user_o    = out_user_q;
  assign deny_count_o       = out_cnt_q;
  assign found_o            = out_found_q;
  assign table_overflowed_o = out_ovf_q;
  assign last_o             = out_last_q;

  // Checks
  `DACT_ASSERT_IMPL(a_fill_order, state_q == ST_IDLE, (valid_vec & (valid_vec + MAX_USERS'(1))) == '0, "table entries not filled in order")
  `DACT_ASSERT_IMPL(a_load_free, load, slot_free, "result overwritten while stalled")
  `DACT_ASSERT_IMPL(a_marker_last, out_valid_o && !found_o, last_o, "empty marker not last")

endmodule

`default_nettype wire
